### rtl/bvs_pkg.sv
package bvs_pkg;

   // Storage geometry
   localparam int CapBits    = 1024;
   localparam int StoreBytes = CapBits / 8;
   localparam int AddrW      = $clog2(StoreBytes);
   localparam int LenW       = 11;
   localparam int IdxW       = 10;
   localparam int CntW       = 11;
   localparam int PosW       = 12;   // bit positions and bounds, with headroom
   localparam int PtrW       = 10;   // signed source byte pointer
   localparam int StepW      = AddrW + 1;

   typedef enum logic [3:0] {
      CMD_SET    = 4'd0,
      CMD_PUSH   = 4'd1,
      CMD_POP    = 4'd2,
      CMD_FILLR  = 4'd3,
      CMD_FILLA  = 4'd4,
      CMD_SHUP   = 4'd5,
      CMD_SHDN   = 4'd6,
      CMD_RESIZE = 4'd7,
      CMD_READ   = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_FILL,
      MODE_UP,
      MODE_DOWN
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SWEEP,
      S_DRAIN,
      S_FETCH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [3:0]      command;
      logic [IdxW-1:0] index;
      logic [CntW-1:0] count;
      logic            bit_value;
      logic            fill_on_grow;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [LenW-1:0] length;
      logic [7:0]      byte_at_index;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic decode;
      logic sweep;
      logic fetch;
      logic load;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_req;
      logic sweep_last;
      logic out_free;
   } sts_type;

endpackage

### rtl/bvs_ctrl.sv
module bvs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bvs_pkg::sts_type sts,
   output bvs_pkg::ctl_type ctl
);
   import bvs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = sts.sweep_req ? S_SWEEP : S_FETCH;
         end
         S_SWEEP: begin
            if (sts.sweep_last) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_FETCH;
         S_FETCH: state_in = S_DONE;
         S_DONE: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            ctl.latch = req_valid;
         end
         S_DECODE: ctl.decode = 1'b1;
         S_SWEEP:  ctl.sweep  = 1'b1;
         S_DRAIN:  ;
         S_FETCH:  ctl.fetch  = 1'b1;
         S_DONE:   ctl.load   = sts.out_free;
         default:  ;
      endcase
   end

endmodule

### rtl/bvs_dpath.sv
module bvs_dpath (
   input  logic             clock,
   input  logic             reset,
   input  bvs_pkg::ctl_type ctl,
   output bvs_pkg::sts_type sts,
   input  bvs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bvs_pkg::rsp_type rsp_data
);
   import bvs_pkg::*;

   // byte store with per-byte valid bits (invalid reads as zero)
   logic [7:0]            mem [StoreBytes];
   logic [StoreBytes-1:0] vld_ff;

   req_type               item_ff;
   logic [LenW-1:0]       len_ff;
   logic [1:0]            status_ff;

   // decoded sweep setup
   logic [PosW-1:0]       lo_ff, hi_ff;
   logic signed [PosW-1:0] limit_ff;
   mode_type              mode_ff;
   logic [2:0]            r_ff;
   logic                  desc_ff;
   logic [StepW-1:0]      last_ff, step_ff;
   logic [PtrW-1:0]       src_ptr_ff;
   logic [AddrW-1:0]      dst_rd_ff;

   // pipeline
   logic                  wr_pend_ff;
   logic [AddrW-1:0]      wr_addr_ff;
   logic [7:0]            a_data_ff, b_data_ff, prev_a_ff;
   logic                  a_ok_ff, b_ok_ff;
   logic [7:0]            a_byte, b_byte, new_byte;
   logic [AddrW-1:0]      b_addr;

   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   // decode results
   logic [1:0]            d_status;
   logic [LenW-1:0]       d_len;
   logic [PosW-1:0]       d_lo, d_hi, d_hm1;
   mode_type              d_mode;
   logic                  d_wr, d_sweep;
   logic [AddrW-1:0]      d_blo, d_bhi;
   logic [PosW-1:0]       idx_x, cnt_x, len_x;

   // command decode
   always_comb begin
      idx_x    = PosW'(item_ff.index);
      cnt_x    = PosW'(item_ff.count);
      len_x    = PosW'(len_ff);
      d_status = ST_OK;
      d_len    = len_ff;
      d_lo     = '0;
      d_hi     = '0;
      d_mode   = MODE_FILL;
      d_wr     = 1'b0;
      unique case (item_ff.command) inside
         CMD_SET: begin
            if (idx_x >= len_x) begin
               d_status = ST_RANGE;
            end else begin
               d_lo = idx_x;
               d_hi = idx_x + PosW'(1);
               d_wr = 1'b1;
            end
         end
         CMD_PUSH: begin
            if (len_x >= PosW'(CapBits)) begin
               d_status = ST_FULL;
            end else begin
               d_lo  = len_x;
               d_hi  = len_x + PosW'(1);
               d_len = len_ff + LenW'(1);
               d_wr  = 1'b1;
            end
         end
         CMD_POP: begin
            if (len_ff == '0) d_status = ST_EMPTY;
            else d_len = len_ff - LenW'(1);
         end
         CMD_FILLR: begin
            if (item_ff.count != '0) begin
               if (idx_x + cnt_x > len_x) begin
                  d_status = ST_RANGE;
               end else begin
                  d_lo = idx_x;
                  d_hi = idx_x + cnt_x;
                  d_wr = 1'b1;
               end
            end
         end
         CMD_FILLA: begin
            d_hi = len_x;
            d_wr = 1'b1;
         end
         CMD_SHUP, CMD_SHDN: begin
            if (item_ff.count != '0) begin
               d_hi   = len_x;
               d_mode = (item_ff.command == CMD_SHUP) ? MODE_UP : MODE_DOWN;
               d_wr   = 1'b1;
            end
         end
         CMD_RESIZE: begin
            if (cnt_x > PosW'(CapBits)) begin
               d_status = ST_FULL;
            end else begin
               d_len = item_ff.count;
               if (cnt_x > len_x && item_ff.fill_on_grow) begin
                  d_lo = len_x;
                  d_hi = cnt_x;
                  d_wr = 1'b1;
               end
            end
         end
         CMD_READ: ;
         default: d_status = ST_RANGE;
      endcase
      d_sweep = d_wr && (d_hi > d_lo);
      d_hm1   = d_hi - PosW'(1);
      d_blo   = d_lo[AddrW+2:3];
      d_bhi   = d_hm1[AddrW+2:3];
   end

   assign sts.sweep_req  = d_sweep;
   assign sts.sweep_last = (step_ff == last_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   // item, length and setup registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (ctl.decode) begin
         len_ff <= d_len;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) item_ff <= req_data;
      if (ctl.decode) begin
         status_ff <= d_status;
         lo_ff     <= d_lo;
         hi_ff     <= d_hi;
         limit_ff  <= $signed(len_x) - $signed(cnt_x);
         mode_ff   <= d_mode;
         r_ff      <= item_ff.count[2:0];
         desc_ff   <= (d_mode == MODE_UP);
         last_ff   <= StepW'(d_bhi) - StepW'(d_blo) + StepW'(1);
         step_ff   <= '0;
         if (d_mode == MODE_UP) begin
            src_ptr_ff <= PtrW'(d_bhi) - PtrW'(item_ff.count[CntW-1:3]);
            dst_rd_ff  <= d_bhi + AddrW'(1);
         end else begin
            src_ptr_ff <= PtrW'(d_blo) + PtrW'(item_ff.count[CntW-1:3]);
            dst_rd_ff  <= d_blo - AddrW'(1);
         end
      end else if (ctl.sweep) begin
         step_ff    <= step_ff + StepW'(1);
         src_ptr_ff <= desc_ff ? src_ptr_ff - PtrW'(1) : src_ptr_ff + PtrW'(1);
         dst_rd_ff  <= desc_ff ? dst_rd_ff - AddrW'(1) : dst_rd_ff + AddrW'(1);
      end
   end

   // write pipeline: a write lands in the cycle after its reads
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= ctl.sweep && (step_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= dst_rd_ff;
      prev_a_ff  <= a_byte;
   end

   assign b_addr = ctl.fetch ? item_ff.index[IdxW-1:3] : dst_rd_ff;

   // memory ports
   always_ff @(posedge clock) begin
      a_data_ff <= mem[src_ptr_ff[AddrW-1:0]];
      if (ctl.sweep || ctl.fetch) b_data_ff <= mem[b_addr];
      if (wr_pend_ff) mem[wr_addr_ff] <= new_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         a_ok_ff <= 1'b0;
         b_ok_ff <= 1'b0;
      end else begin
         a_ok_ff <= (src_ptr_ff[PtrW-1:AddrW] == '0) && vld_ff[src_ptr_ff[AddrW-1:0]];
         if (ctl.sweep || ctl.fetch) b_ok_ff <= vld_ff[b_addr];
         if (wr_pend_ff) vld_ff[wr_addr_ff] <= 1'b1;
      end
   end

   assign a_byte = a_ok_ff ? a_data_ff : 8'h00;
   assign b_byte = b_ok_ff ? b_data_ff : 8'h00;

   // merge one destination byte
   always_comb begin
      logic [15:0]     up16, dn16;
      logic [PosW-1:0] pos;
      logic            fbit;
      up16     = {prev_a_ff, a_byte} << r_ff;
      dn16     = {a_byte, prev_a_ff} >> r_ff;
      new_byte = b_byte;
      for (int b = 0; b < 8; b++) begin
         pos = PosW'({wr_addr_ff, 3'(b)});
         case (mode_ff)
            MODE_UP:   fbit = up16[8+b];
            MODE_DOWN: fbit = dn16[b] && ($signed(pos) < limit_ff);
            default:   fbit = item_ff.bit_value;
         endcase
         if (pos >= lo_ff && pos < hi_ff) new_byte[b] = fbit;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.length        <= len_ff;
         rsp_ff.byte_at_index <= b_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/bit_vector_store.sv
// Bit vector store: a vector of up to 1024 bits held in 128 bytes.
// Command words come in on req_valid/req_ready (req_data), one result word
// per command leaves on rsp_valid/rsp_ready (rsp_data): status, length after
// the command, and the stored byte holding bit req_data.index.
// One command is in work at a time. A command that writes no storage is
// decoded, reads the indexed byte and then loads its result; the next
// command is accepted once the block is back in idle. A writing command
// walks the bytes it touches one per cycle through a two-read, one-write
// byte memory, drains its last write and then finishes like the others.
// The byte walk sets the throughput.
// Reset empties the vector and marks every byte as zero through per-byte
// valid bits; no clearing pass is needed and req_ready rises at once.
// The result sits in an output register; the next command is accepted while
// it waits, and the block holds its following result until rsp_ready
// frees that register.
module bit_vector_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bvs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bvs_pkg::rsp_type rsp_data
);
   import bvs_pkg::*;

   ctl_type ctl;
   sts_type sts;

   bvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   bvs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
